>>> src/ptrw_pkg.sv
package ptrw_pkg;

   // Table geometry.
   localparam int INDEX_BITS = 9;
   localparam int PAGE_BITS  = 12;
   localparam int PHYS_BITS  = 46;
   localparam int LEVELS     = 4;
   localparam int LEVEL_W    = 2;
   localparam int ENTRY_SHIFT = 3;

   // Result queue geometry. The depth must be a power of two so the pointers wrap freely.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef logic [QPTR_W-1:0] qptr_type;
   typedef logic [QCNT_W-1:0] qcnt_type;

   localparam logic [63:0] ABSENT_ADDR = 64'h0000_dead_0000_0000;

   // Configuration register indexes.
   localparam logic CSR_ROOT_BASE = 1'b0;
   localparam logic CSR_VERBOSE   = 1'b1;

   // Request function codes.
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_READ_RESP = 1'b1;

   typedef enum logic [1:0] {
      KIND_READ   = 2'd0,
      KIND_MAPPED = 2'd1,
      KIND_ABSENT = 2'd2,
      KIND_FINISH = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [63:0]            address;
      logic [PHYS_BITS-1:0]   phys_page;
      logic                   young;
      logic                   dirty;
      logic                   writable;
      logic                   user;
      logic                   last;
   } rsp_rec_type;

   // Bit position of the table index for a level; level 0 is the root table.
   function automatic int level_shift(input logic [LEVEL_W-1:0] lvl);
      return PAGE_BITS + (LEVELS - 1 - int'(lvl)) * INDEX_BITS;
   endfunction

   // Address of the entry that translates va in the table at base.
   function automatic logic [63:0] entry_addr(input logic [63:0] base,
                                              input logic [63:0] va,
                                              input logic [LEVEL_W-1:0] lvl);
      logic [INDEX_BITS-1:0] idx;
      idx = INDEX_BITS'(va >> level_shift(lvl));
      return base + 64'({idx, {ENTRY_SHIFT{1'b0}}});
   endfunction

   // Address span covered by one entry at a level.
   function automatic logic [63:0] level_span(input logic [LEVEL_W-1:0] lvl);
      return 64'(1) << level_shift(lvl);
   endfunction

endpackage

>>> src/page_table_range_walker_unit.sv
// A response is written into the result queue before it appears on rsp_*; a leaf entry that
// yields a page record, or an absent marker in verbose mode, gives two responses, the record first.
// Throughput: one request per cycle while the result queue has room for two responses.
// Reset (synchronous, active high) clears the walk state, the configuration registers
// and the result queue; the block accepts requests as soon as reset is released.
module page_table_range_walker_unit (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration write port.
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [63:0]                     csr_wdata,
   // Request channel: walk starts and memory read responses.
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_func,
   input  logic [63:0]                     req_begin_va,
   input  logic [63:0]                     req_end_va,
   input  logic [63:0]                     req_read_data,
   // Result channel: read requests, page records, absent markers and the finish marker.
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_kind,
   output logic [63:0]                     rsp_address,
   output logic [ptrw_pkg::PHYS_BITS-1:0]  rsp_phys_page,
   output logic                            rsp_young,
   output logic                            rsp_dirty,
   output logic                            rsp_writable,
   output logic                            rsp_user,
   output logic                            rsp_last
);

   // The walk itself is a single pass of logic per request: every request updates
   // the walk state in the cycle it is accepted and pushes zero, one or two
   // responses into a four-entry result queue. The queue decouples the two sides,
   // so a new request is taken while earlier responses are still waiting.

   // Configuration registers.
   logic [63:0] root_base_ff;
   logic        verbose_ff;

   // Walk state.
   logic [63:0]                      current_va_ff, current_va_in;
   logic [63:0]                      end_address_ff, end_address_in;
   logic [ptrw_pkg::LEVEL_W-1:0]     walk_level_ff, walk_level_in;
   logic                             walking_ff, walking_in;

   // Result queue.
   ptrw_pkg::rsp_rec_type            queue_ff [ptrw_pkg::QDEPTH];
   ptrw_pkg::qptr_type               head_ff, head_in;
   ptrw_pkg::qptr_type               tail_ff, tail_in;
   ptrw_pkg::qcnt_type               count_ff, count_in;

   ptrw_pkg::rsp_rec_type            rec0, rec1;
   logic [1:0]                       n_push;
   logic                             req_take;
   logic                             rsp_take;
   logic [63:0]                      step_va;
   ptrw_pkg::rsp_rec_type            blank_rec;
   ptrw_pkg::rsp_rec_type            next_rec;
   ptrw_pkg::rsp_rec_type            leaf_rec;

   assign req_ready = (count_ff <= ptrw_pkg::qcnt_type'(ptrw_pkg::QDEPTH - 2));
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_take  = rsp_valid && rsp_ready;

   always_comb begin
      blank_rec = '0;
      blank_rec.kind = ptrw_pkg::KIND_READ;
   end

   // Address the walk moves to after this request; only meaningful for starts and
   // for read responses that finish a page or skip a range.
   always_comb begin
      if (req_func == ptrw_pkg::FUNC_START) begin
         step_va = req_begin_va;
      end else if (walk_level_ff == ptrw_pkg::LEVEL_W'(ptrw_pkg::LEVELS - 1)) begin
         step_va = current_va_ff + (64'(1) << ptrw_pkg::PAGE_BITS);
      end else begin
         step_va = current_va_ff + ptrw_pkg::level_span(walk_level_ff);
      end
   end

   // The record that restarts at the root for step_va, or ends the walk.
   always_comb begin
      next_rec = blank_rec;
      next_rec.last = 1'b1;
      if (step_va < end_address_in) begin
         next_rec.kind    = ptrw_pkg::KIND_READ;
         next_rec.address = ptrw_pkg::entry_addr(root_base_ff, step_va, '0);
      end else begin
         next_rec.kind = ptrw_pkg::KIND_FINISH;
      end
   end

   // Page record for a present leaf entry, or the absent marker.
   always_comb begin
      leaf_rec = blank_rec;
      if (req_read_data[0]) begin
         leaf_rec.kind      = ptrw_pkg::KIND_MAPPED;
         leaf_rec.address   = current_va_ff;
         leaf_rec.phys_page = {req_read_data[ptrw_pkg::PHYS_BITS-1:ptrw_pkg::PAGE_BITS],
                               {ptrw_pkg::PAGE_BITS{1'b0}}};
         leaf_rec.young     = req_read_data[5];
         leaf_rec.dirty     = req_read_data[6];
         leaf_rec.writable  = req_read_data[1];
         leaf_rec.user      = req_read_data[2];
      end else begin
         leaf_rec.kind    = ptrw_pkg::KIND_ABSENT;
         leaf_rec.address = ptrw_pkg::ABSENT_ADDR;
      end
   end

   // Main walk decision.
   always_comb begin
      current_va_in  = current_va_ff;
      end_address_in = end_address_ff;
      walk_level_in  = walk_level_ff;
      walking_in     = walking_ff;
      rec0           = next_rec;
      rec1           = next_rec;
      n_push         = 2'd0;
      if (req_func == ptrw_pkg::FUNC_START) begin
         end_address_in = req_end_va;
      end
      if (req_take) begin
         if (req_func == ptrw_pkg::FUNC_START) begin
            current_va_in = step_va;
            walk_level_in = '0;
            walking_in    = (next_rec.kind == ptrw_pkg::KIND_READ);
            n_push        = 2'd1;
         end else if (walking_ff) begin
            if (walk_level_ff != ptrw_pkg::LEVEL_W'(ptrw_pkg::LEVELS - 1)) begin
               if (req_read_data == '0) begin
                  // Empty upper entry: skip this level's whole span.
                  current_va_in = step_va;
                  walk_level_in = '0;
                  walking_in    = (next_rec.kind == ptrw_pkg::KIND_READ);
               end else begin
                  // Descend into the table the entry points to.
                  walk_level_in = walk_level_ff + 1'b1;
                  rec0          = blank_rec;
                  rec0.kind     = ptrw_pkg::KIND_READ;
                  rec0.last     = 1'b1;
                  rec0.address  = ptrw_pkg::entry_addr(req_read_data, current_va_ff,
                                                       walk_level_ff + 1'b1);
               end
               n_push = 2'd1;
            end else begin
               current_va_in = step_va;
               walk_level_in = '0;
               walking_in    = (next_rec.kind == ptrw_pkg::KIND_READ);
               if (req_read_data[0] || verbose_ff) begin
                  rec0   = leaf_rec;
                  n_push = 2'd2;
               end else begin
                  n_push = 2'd1;
               end
            end
         end
      end
   end

   // Queue pointer updates.
   always_comb begin
      head_in  = head_ff + ptrw_pkg::qptr_type'(rsp_take);
      tail_in  = tail_ff + ptrw_pkg::qptr_type'(n_push);
      count_in = count_ff + ptrw_pkg::qcnt_type'(n_push) - ptrw_pkg::qcnt_type'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_base_ff   <= '0;
         verbose_ff     <= 1'b0;
         current_va_ff  <= '0;
         end_address_ff <= '0;
         walk_level_ff  <= '0;
         walking_ff     <= 1'b0;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               ptrw_pkg::CSR_ROOT_BASE: root_base_ff <= csr_wdata;
               ptrw_pkg::CSR_VERBOSE:   verbose_ff   <= csr_wdata[0];
               default: ;
            endcase
         end
         if (req_take) begin
            current_va_ff  <= current_va_in;
            end_address_ff <= end_address_in;
            walk_level_ff  <= walk_level_in;
            walking_ff     <= walking_in;
         end
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Queue payload, no reset needed.
   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         queue_ff[tail_ff] <= rec0;
      end
      if (n_push == 2'd2) begin
         queue_ff[tail_ff + 1'b1] <= rec1;
      end
   end

   assign rsp_kind      = queue_ff[head_ff].kind;
   assign rsp_address   = queue_ff[head_ff].address;
   assign rsp_phys_page = queue_ff[head_ff].phys_page;
   assign rsp_young     = queue_ff[head_ff].young;
   assign rsp_dirty     = queue_ff[head_ff].dirty;
   assign rsp_writable  = queue_ff[head_ff].writable;
   assign rsp_user      = queue_ff[head_ff].user;
   assign rsp_last      = queue_ff[head_ff].last;

endmodule
